>>> rtl/arfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arfc_pkg: shared types, constants and round functions
// Bit-level layers of the AND/rotate/nibble-permutation Feistel cipher, the
// key schedule step, register indexes and the engine state type.
// ----------------------------------------------------------------------------
package arfc_pkg;

  localparam int unsigned HalfW = 64;
  localparam int unsigned RcW   = 7;

  // Mask constants of the G and P layers
  localparam logic [63:0] MaskEvenBytes = 64'h00FF_00FF_00FF_00FF;
  localparam logic [63:0] MaskOddBytes  = 64'hFF00_FF00_FF00_FF00;
  localparam logic [63:0] MaskBit0      = 64'h1111_1111_1111_1111;
  localparam logic [63:0] MaskBit3      = 64'h8888_8888_8888_8888;
  localparam logic [63:0] MaskBit2      = 64'h4444_4444_4444_4444;
  localparam logic [63:0] MaskBit1      = 64'h2222_2222_2222_2222;

  // Configuration register indexes
  localparam logic [1:0] CfgKeyLow   = 2'd0;
  localparam logic [1:0] CfgKeyHigh  = 2'd1;
  localparam logic [1:0] CfgRounds   = 2'd2;
  localparam logic [1:0] CfgDecrypt  = 2'd3;

  localparam logic [RcW-1:0] RoundCountReset = 7'd54;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_ROUND,
    ENG_DONE
  } eng_state_e;

  // Nibble/byte permutation P
  function automatic logic [63:0] perm_p(input logic [63:0] v);
    logic [63:0] e;
    logic [63:0] o;
    e = v & MaskEvenBytes;
    o = v & MaskOddBytes;
    return {e[7:0], e[63:8]} | {o[39:0], o[63:40]};
  endfunction

  function automatic logic [63:0] layer_g0(input logic [63:0] v);
    logic [63:0] w;
    w = v ^ ((v >> 3) & (v >> 2) & MaskBit0);
    w = w ^ ((w << 3) & (w << 2) & MaskBit3);
    return w;
  endfunction

  function automatic logic [63:0] layer_g1(input logic [63:0] v);
    logic [63:0] w;
    w = v ^ ((v >> 1) & (v << 1) & MaskBit2);
    w = w ^ ((w << 1) & (w >> 1) & MaskBit1);
    return w;
  endfunction

  // Round function F(x) = P(G0(x) ^ G1(rotl(x, 4)))
  function automatic logic [63:0] round_f(input logic [63:0] x);
    return perm_p(layer_g0(x) ^ layer_g1({x[59:0], x[63:60]}));
  endfunction

  // A16x3 key schedule step: three nibble rotate-and-mix passes
  // (each pass rotates left by 60, then mixes the top nibble)
  function automatic logic [63:0] key_mix(input logic [63:0] v);
    logic [63:0] w;
    logic [3:0]  n;
    w = v;
    for (int i = 0; i < 3; i++) begin
      w = {w[3:0], w[63:4]};
      n = w[59:56];
      w[63:60] = w[63:60] ^ {n[2:0], n[3]};
      w[59]    = w[59] ^ n[0];
    end
    return w;
  endfunction

endpackage
`default_nettype wire

>>> rtl/and_rotate_feistel_cipher_128.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// and_rotate_feistel_cipher_128: 128-bit AND/rotate Feistel block engine
// ECB block engine with a key RAM, a key expansion sequencer and an
// iterative round engine.
// ----------------------------------------------------------------------------
// A block is accepted in ENG_IDLE, then runs n rounds, n being the round count
// (54 after reset) capped at MAX_ROUNDS, at one round per cycle through the
// single shared round unit, and is then handed to the output register from
// ENG_DONE once that register is free. The block is not ready during that time,
// but the result may wait in the output register while the next block is
// taken. After reset and after each configuration write the round keys are
// rebuilt into the key RAM at one key per cycle; no block is accepted until
// that finishes.
// ----------------------------------------------------------------------------
module and_rotate_feistel_cipher_128
  import arfc_pkg::*;
#(
  parameter int unsigned MAX_ROUNDS = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Configuration write port
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_addr_i,
  input  wire logic [63:0]  cfg_wdata_i,
  // Input block stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,   // [63:0] block_high, [127:64] block_low
  // Result stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [127:0] m_axis_tdata    // [63:0] result_high, [127:64] result_low
);

  localparam int unsigned AW = $clog2(MAX_ROUNDS);
  localparam int unsigned CW = $clog2(MAX_ROUNDS + 1);

  logic [63:0]    key_low_q, key_high_q;
  logic [RcW-1:0] round_count_q;
  logic           decrypt_q;
  logic           cfg_hit;
  logic [7:0]     rc_ext;
  logic [CW-1:0]  n_rounds;

  logic           keys_busy;
  logic           key_we;
  logic [AW-1:0]  key_waddr;
  logic [63:0]    key_wdata;
  logic [AW-1:0]  key_raddr;
  logic [63:0]    key_rdata;
  logic [63:0]    result_high, result_low;

  // Configuration registers
  always_comb begin
    case (cfg_addr_i)
      CfgKeyLow, CfgKeyHigh, CfgRounds, CfgDecrypt: cfg_hit = cfg_we_i;
      default:                                      cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q     <= '0;
      key_high_q    <= '0;
      round_count_q <= RoundCountReset;
      decrypt_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgKeyLow:  key_low_q     <= cfg_wdata_i;
        CfgKeyHigh: key_high_q    <= cfg_wdata_i;
        CfgRounds:  round_count_q <= cfg_wdata_i[RcW-1:0];
        CfgDecrypt: decrypt_q     <= cfg_wdata_i[0];
        default:    ;
      endcase
    end
  end

  // Round count saturates at MAX_ROUNDS
  assign rc_ext   = {1'b0, round_count_q};
  assign n_rounds = (rc_ext > 8'(MAX_ROUNDS)) ? CW'(MAX_ROUNDS) : CW'(rc_ext);

  arfc_key_exp #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_key_exp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cfg_hit),
    .key_low_i  (key_low_q),
    .key_high_i (key_high_q),
    .n_rounds_i (n_rounds),
    .decrypt_i  (decrypt_q),
    .busy_o     (keys_busy),
    .we_o       (key_we),
    .waddr_o    (key_waddr),
    .wdata_o    (key_wdata)
  );

  arfc_ram #(
    .WIDTH (HalfW),
    .DEPTH (MAX_ROUNDS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  arfc_round_eng #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_round_eng (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .block_high_i  (s_axis_tdata[63:0]),
    .block_low_i   (s_axis_tdata[127:64]),
    .keys_busy_i   (keys_busy),
    .n_rounds_i    (n_rounds),
    .key_raddr_o   (key_raddr),
    .key_rdata_i   (key_rdata),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .result_high_o (result_high),
    .result_low_o  (result_low)
  );

  assign m_axis_tdata = {result_low, result_high};

endmodule
`default_nettype wire

>>> rtl/arfc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arfc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module arfc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> rtl/arfc_key_exp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arfc_key_exp: round key expansion sequencer
// Produces one round key per cycle by the A16x3 recurrence and writes it to
// the key RAM, in reverse address order for decryption. Runs after reset and
// after every configuration write.
// ----------------------------------------------------------------------------
module arfc_key_exp
  import arfc_pkg::*;
#(
  parameter int unsigned MAX_ROUNDS = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic [63:0]                        key_low_i,
  input  wire logic [63:0]                        key_high_i,
  input  wire logic [$clog2(MAX_ROUNDS+1)-1:0]    n_rounds_i,
  input  wire logic                               decrypt_i,
  output logic                                    busy_o,
  output logic                                    we_o,
  output logic      [$clog2(MAX_ROUNDS)-1:0]      waddr_o,
  output logic      [63:0]                        wdata_o
);

  localparam int unsigned AW = $clog2(MAX_ROUNDS);
  localparam int unsigned CW = $clog2(MAX_ROUNDS + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [63:0]   kprev_q, kcur_q;
  logic [CW:0]   idx_nxt;
  logic [CW-1:0] rev_idx;

  assign idx_nxt = {1'b0, idx_q} + (CW + 1)'(1);
  assign rev_idx = n_rounds_i - idx_q - CW'(1);

  // Key value and write address for the current index
  always_comb begin
    case (idx_q)
      CW'(0):  wdata_o = key_low_i;
      CW'(1):  wdata_o = key_high_i;
      default: wdata_o = key_mix(kcur_q) ^ kprev_q ^ 64'(idx_q - CW'(1));
    endcase
    we_o    = busy_q && (idx_q < n_rounds_i);
    waddr_o = decrypt_i ? rev_idx[AW-1:0] : idx_q[AW-1:0];
  end

  // Sequencer next state
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (busy_q) begin
      idx_d = idx_nxt[CW-1:0];
      if (idx_nxt >= {1'b0, n_rounds_i}) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  // Last two keys of the recurrence
  always_ff @(posedge clk_i) begin
    if (we_o && !start_i) begin
      kprev_q <= kcur_q;
      kcur_q  <= wdata_o;
    end
  end

  assign busy_o = busy_q;

endmodule
`default_nettype wire

>>> rtl/arfc_round_eng.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arfc_round_eng: iterative Feistel round engine
// One shared round unit applied once per cycle under a small sequencer,
// reading each round key from RAM ahead of its use; result goes to an output
// register so the next block can be taken while it waits.
// ----------------------------------------------------------------------------
module arfc_round_eng
  import arfc_pkg::*;
#(
  parameter int unsigned MAX_ROUNDS = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [63:0]                      block_high_i,
  input  wire logic [63:0]                      block_low_i,
  input  wire logic                             keys_busy_i,
  input  wire logic [$clog2(MAX_ROUNDS+1)-1:0]  n_rounds_i,
  output logic      [$clog2(MAX_ROUNDS)-1:0]    key_raddr_o,
  input  wire logic [63:0]                      key_rdata_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [63:0]                      result_high_o,
  output logic      [63:0]                      result_low_o
);

  localparam int unsigned AW = $clog2(MAX_ROUNDS);
  localparam int unsigned CW = $clog2(MAX_ROUNDS + 1);

  eng_state_e    state_q, state_d;
  logic [AW-1:0] rnd_q, rnd_d;
  logic          out_valid_q, out_valid_d;
  logic [63:0]   left_q, right_q;
  logic [63:0]   res_high_q, res_low_q;
  logic          accept;
  logic          last_round;
  logic          out_free;
  logic          out_load;
  logic [63:0]   round_out;

  // Shared round unit
  assign round_out = right_q ^ round_f(left_q) ^ key_rdata_i;

  assign in_ready_o = (state_q == ENG_IDLE) && !keys_busy_i;
  assign accept     = in_valid_i && in_ready_o;
  assign last_round = ((CW'(rnd_q) + CW'(1)) == n_rounds_i);
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = (state_q == ENG_DONE) && out_free;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    key_raddr_o = '0;
    case (state_q)
      ENG_IDLE: begin
        rnd_d = '0;
        if (accept) begin
          state_d = (n_rounds_i == '0) ? ENG_DONE : ENG_ROUND;
        end
      end
      ENG_ROUND: begin
        rnd_d       = rnd_q + AW'(1);
        key_raddr_o = rnd_q + AW'(1);
        if (last_round) begin
          state_d = ENG_DONE;
        end
      end
      ENG_DONE: begin
        if (out_free) begin
          state_d = ENG_IDLE;
        end
      end
      default: state_d = ENG_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ENG_IDLE;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Feistel halves and result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      left_q  <= block_high_i;
      right_q <= block_low_i;
    end else if (state_q == ENG_ROUND) begin
      left_q  <= round_out;
      right_q <= left_q;
    end
    if (out_load) begin
      res_high_q <= right_q;
      res_low_q  <= left_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_high_o = res_high_q;
  assign result_low_o  = res_low_q;

endmodule
`default_nettype wire
